// ===== design/lfps_pkg.sv =====
// Shared types and constants for the line-follow PID steering block.
`timescale 1ns / 1ps

package lfps_pkg;

  // Configuration register field widths
  localparam int TARGET_W = 10;
  localparam int GAIN_W   = 26;
  localparam int LIMIT_W  = 7;
  localparam int BASE_W   = 8;

  // Accumulator and result widths
  localparam int SUM_W   = 32;
  localparam int POWER_W = 9;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEVEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KD_GAIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PID_LIMIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_POWER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_SIGN    = 3'd6;

  // Reset values
  localparam logic [TARGET_W-1:0]      RST_TARGET_LEVEL = 10'd85;
  localparam logic [GAIN_W-1:0]        RST_KP_GAIN      = 26'd1107296;
  localparam logic [GAIN_W-1:0]        RST_KI_GAIN      = 26'd101;
  localparam logic [GAIN_W-1:0]        RST_KD_GAIN      = 26'd5033165;
  localparam logic [LIMIT_W-1:0]       RST_PID_LIMIT    = 7'd40;
  localparam logic signed [BASE_W-1:0] RST_CRUISE_POWER = 8'sd0;
  localparam logic                     RST_EDGE_SIGN    = 1'b0;

  typedef struct packed {
    logic [TARGET_W-1:0]      target_level;
    logic [GAIN_W-1:0]        kp_gain;
    logic [GAIN_W-1:0]        ki_gain;
    logic [GAIN_W-1:0]        kd_gain;
    logic [LIMIT_W-1:0]       pid_limit;
    logic signed [BASE_W-1:0] cruise_power;
    logic                     edge_sign;
  } cfg_t;

endpackage

// ===== design/line_follow_pid_steering_top.sv =====
// Top level of the line-follow PID steering block: configuration and stage control.
`timescale 1ns / 1ps
//
// Usage
//   Input channel: in_valid / in_stall with one green_sample per transaction.
//   Output channel: out_valid / out_stall with left_power and right_power.
//   A transaction completes at a rising edge where valid is high and stall low.
//   Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high, so each write takes effect at the edge it is presented.
//   Indexes beyond the register list are ignored. Write only while idle.
// Timing
//   Four register stages (input, error/accumulator, products, result): a
//   sample goes from the input register through error and products to result.
//   One transaction per cycle sustained while out_stall is low; the accumulator
//   update is registered with the error, so consecutive samples follow back to back.
// Reset
//   Synchronous rst clears every stage valid, the previous error and the pair
//   sum, and loads the register defaults.
// Stall
//   A stalled result holds in the output register; each stage advances while
//   the one after it is empty or advancing, so bubbles are squeezed out and
//   in_stall rises only when all four stages hold transactions.

module line_follow_pid_steering_top #(
  parameter int SAMPLE_BITS    = 10,
  parameter int GAIN_FRAC_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [SAMPLE_BITS-1:0]                green_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [lfps_pkg::POWER_W-1:0]   left_power,
  output logic signed [lfps_pkg::POWER_W-1:0]   right_power,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lfps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lfps_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // Error width covers target minus sample for either operand being wider
  localparam int ERR_W = ((SAMPLE_BITS > lfps_pkg::TARGET_W) ?
                          SAMPLE_BITS : lfps_pkg::TARGET_W) + 1;

  lfps_pkg::cfg_t cfg;

  logic sample_valid;
  logic err_valid;
  logic prod_valid;

  logic adv_err;
  logic adv_prod;
  logic adv_out;
  logic load_in;

  logic signed [ERR_W-1:0]           err;
  logic signed [ERR_W:0]             delta;
  logic signed [lfps_pkg::SUM_W-1:0] pair_sum;

  logic signed [lfps_pkg::GAIN_W+ERR_W:0]           prod_kp;
  logic signed [lfps_pkg::GAIN_W+lfps_pkg::SUM_W:0] prod_ki;
  logic signed [lfps_pkg::GAIN_W+ERR_W+1:0]         prod_kd;

  // Configuration registers: always ready, unknown indexes drop
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_level <= lfps_pkg::RST_TARGET_LEVEL;
      cfg.kp_gain      <= lfps_pkg::RST_KP_GAIN;
      cfg.ki_gain      <= lfps_pkg::RST_KI_GAIN;
      cfg.kd_gain      <= lfps_pkg::RST_KD_GAIN;
      cfg.pid_limit    <= lfps_pkg::RST_PID_LIMIT;
      cfg.cruise_power <= lfps_pkg::RST_CRUISE_POWER;
      cfg.edge_sign    <= lfps_pkg::RST_EDGE_SIGN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lfps_pkg::CFG_TARGET_LEVEL: begin
          cfg.target_level <= cfg_data[lfps_pkg::TARGET_W-1:0];
        end
        lfps_pkg::CFG_KP_GAIN: begin
          cfg.kp_gain <= cfg_data[lfps_pkg::GAIN_W-1:0];
        end
        lfps_pkg::CFG_KI_GAIN: begin
          cfg.ki_gain <= cfg_data[lfps_pkg::GAIN_W-1:0];
        end
        lfps_pkg::CFG_KD_GAIN: begin
          cfg.kd_gain <= cfg_data[lfps_pkg::GAIN_W-1:0];
        end
        lfps_pkg::CFG_PID_LIMIT: begin
          cfg.pid_limit <= cfg_data[lfps_pkg::LIMIT_W-1:0];
        end
        lfps_pkg::CFG_CRUISE_POWER: begin
          cfg.cruise_power <= $signed(cfg_data[lfps_pkg::BASE_W-1:0]);
        end
        lfps_pkg::CFG_EDGE_SIGN: begin
          cfg.edge_sign <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Stage advance chain: a stage loads when it is empty or its successor moves
  assign adv_out  = !out_valid || !out_stall;
  assign adv_prod = !prod_valid || adv_out;
  assign adv_err  = !err_valid || adv_prod;
  assign load_in  = !sample_valid || adv_err;
  assign in_stall = !load_in;

  lfps_error #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ERR_W       (ERR_W)
  ) u_error (
    .clk          (clk),
    .rst          (rst),
    .load_in      (load_in),
    .in_valid     (in_valid),
    .green_sample (green_sample),
    .adv          (adv_err),
    .target_level (cfg.target_level),
    .sample_valid (sample_valid),
    .err_valid    (err_valid),
    .err          (err),
    .delta        (delta),
    .pair_sum     (pair_sum)
  );

  lfps_mult #(
    .ERR_W (ERR_W)
  ) u_mult (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv_prod),
    .err_valid  (err_valid),
    .err        (err),
    .delta      (delta),
    .pair_sum   (pair_sum),
    .cfg        (cfg),
    .prod_valid (prod_valid),
    .prod_kp    (prod_kp),
    .prod_ki    (prod_ki),
    .prod_kd    (prod_kd)
  );

  lfps_mix #(
    .ERR_W          (ERR_W),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_mix (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv_out),
    .prod_valid  (prod_valid),
    .prod_kp     (prod_kp),
    .prod_ki     (prod_ki),
    .prod_kd     (prod_kd),
    .cfg         (cfg),
    .out_valid   (out_valid),
    .left_power  (left_power),
    .right_power (right_power)
  );

`ifndef SYNTHESIS
  // An empty result register means the whole chain can move
  a_no_stall_when_out_empty: assert property (
    @(posedge clk) disable iff (rst) !out_valid |-> !in_stall
  ) else $error("input stalled while the result register is empty");

  // Input stalls only with every stage occupied and the result held
  a_stall_only_when_full: assert property (
    @(posedge clk) disable iff (rst)
    in_stall |-> (sample_valid && err_valid && prod_valid && out_valid && out_stall)
  ) else $error("input stalled with a bubble in the pipeline");

  // A result appears only from a valid product stage
  a_result_from_products: assert property (
    @(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(prod_valid)
  ) else $error("result appeared without a product transaction");

  // Reset empties the output
  a_reset_clears_output: assert property (
    @(posedge clk) (!rst && $past(rst)) |-> !out_valid
  ) else $error("result valid straight after reset");
`endif

endmodule

// ===== design/lfps_error.sv =====
// Input register, error formation and saturating trapezoidal accumulator.
`timescale 1ns / 1ps

module lfps_error #(
  parameter int SAMPLE_BITS = 10,
  parameter int ERR_W       = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load_in,
  input  logic                          in_valid,
  input  logic [SAMPLE_BITS-1:0]        green_sample,
  input  logic                          adv,
  input  logic [lfps_pkg::TARGET_W-1:0] target_level,
  output logic                          sample_valid,
  output logic                          err_valid,
  output logic signed [ERR_W-1:0]       err,
  output logic signed [ERR_W:0]         delta,
  output logic signed [lfps_pkg::SUM_W-1:0] pair_sum
);

  localparam int PS_W = lfps_pkg::SUM_W + 2;

  logic [SAMPLE_BITS-1:0]            sample;
  logic signed [ERR_W-1:0]           previous_error;
  logic signed [lfps_pkg::SUM_W-1:0] error_pair_sum;

  logic signed [ERR_W-1:0]           err_next;
  logic signed [ERR_W:0]             delta_next;
  logic signed [PS_W-1:0]            pair_wide;
  logic signed [lfps_pkg::SUM_W-1:0] sum_next;

  always_comb begin
    err_next   = $signed(ERR_W'(target_level)) - $signed(ERR_W'(sample));
    delta_next = (ERR_W+1)'(err_next) - (ERR_W+1)'(previous_error);
    pair_wide  = PS_W'(error_pair_sum) + PS_W'(err_next) + PS_W'(previous_error);
    // saturate when the top bits disagree
    if (pair_wide[PS_W-1:lfps_pkg::SUM_W-1] == '0 ||
        pair_wide[PS_W-1:lfps_pkg::SUM_W-1] == '1) begin
      sum_next = pair_wide[lfps_pkg::SUM_W-1:0];
    end else if (pair_wide[PS_W-1]) begin
      sum_next = {1'b1, {(lfps_pkg::SUM_W-1){1'b0}}};
    end else begin
      sum_next = {1'b0, {(lfps_pkg::SUM_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid   <= 1'b0;
      err_valid      <= 1'b0;
      previous_error <= '0;
      error_pair_sum <= '0;
    end else begin
      if (load_in) begin
        sample_valid <= in_valid;
      end
      if (adv) begin
        err_valid <= sample_valid;
        if (sample_valid) begin
          previous_error <= err_next;
          error_pair_sum <= sum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_in && in_valid) begin
      sample <= green_sample;
    end
    if (adv && sample_valid) begin
      err      <= err_next;
      delta    <= delta_next;
      pair_sum <= sum_next;
    end
  end

endmodule

// ===== design/lfps_mult.sv =====
// Product stage: the three gain multiplications, registered.
`timescale 1ns / 1ps

module lfps_mult #(
  parameter int ERR_W = 11
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              err_valid,
  input  logic signed [ERR_W-1:0]           err,
  input  logic signed [ERR_W:0]             delta,
  input  logic signed [lfps_pkg::SUM_W-1:0] pair_sum,
  input  lfps_pkg::cfg_t                    cfg,
  output logic                              prod_valid,
  output logic signed [lfps_pkg::GAIN_W+ERR_W:0]          prod_kp,
  output logic signed [lfps_pkg::GAIN_W+lfps_pkg::SUM_W:0] prod_ki,
  output logic signed [lfps_pkg::GAIN_W+ERR_W+1:0]        prod_kd
);

  localparam int PKP_W = lfps_pkg::GAIN_W + ERR_W + 1;
  localparam int PKI_W = lfps_pkg::GAIN_W + lfps_pkg::SUM_W + 1;
  localparam int PKD_W = lfps_pkg::GAIN_W + ERR_W + 2;

  logic signed [PKP_W-1:0] kp_next;
  logic signed [PKI_W-1:0] ki_next;
  logic signed [PKD_W-1:0] kd_next;

  always_comb begin
    kp_next = $signed(PKP_W'(cfg.kp_gain)) * PKP_W'(err);
    ki_next = $signed(PKI_W'(cfg.ki_gain)) * PKI_W'(pair_sum);
    kd_next = $signed(PKD_W'(cfg.kd_gain)) * PKD_W'(delta);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (adv) begin
      prod_valid <= err_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && err_valid) begin
      prod_kp <= kp_next;
      prod_ki <= ki_next;
      prod_kd <= kd_next;
    end
  end

endmodule

// ===== design/lfps_mix.sv =====
// Result stage: sum the terms, clamp, steer and truncate to motor powers.
`timescale 1ns / 1ps

module lfps_mix #(
  parameter int ERR_W          = 11,
  parameter int GAIN_FRAC_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              prod_valid,
  input  logic signed [lfps_pkg::GAIN_W+ERR_W:0]          prod_kp,
  input  logic signed [lfps_pkg::GAIN_W+lfps_pkg::SUM_W:0] prod_ki,
  input  logic signed [lfps_pkg::GAIN_W+ERR_W+1:0]        prod_kd,
  input  lfps_pkg::cfg_t                    cfg,
  output logic                              out_valid,
  output logic signed [lfps_pkg::POWER_W-1:0] left_power,
  output logic signed [lfps_pkg::POWER_W-1:0] right_power
);

  localparam int PKI_W = lfps_pkg::GAIN_W + lfps_pkg::SUM_W + 1;
  localparam int PKD_W = lfps_pkg::GAIN_W + ERR_W + 2;
  localparam int WIDE_W = (PKI_W > PKD_W) ? PKI_W : PKD_W;
  localparam int ACC_W = (WIDE_W > GAIN_FRAC_BITS + 10) ? WIDE_W + 2 : GAIN_FRAC_BITS + 12;

  logic signed [ACC_W-1:0] pid_raw;
  logic signed [ACC_W-1:0] lim;
  logic signed [ACC_W-1:0] pid;
  logic signed [ACC_W-1:0] steer;
  logic signed [ACC_W-1:0] base_q;
  logic signed [ACC_W-1:0] left_q;
  logic signed [ACC_W-1:0] right_q;
  logic signed [ACC_W-1:0] left_int;
  logic signed [ACC_W-1:0] right_int;

  always_comb begin
    pid_raw = ACC_W'(prod_kp) + ACC_W'(prod_ki) + ACC_W'(prod_kd);
    lim     = $signed(ACC_W'(cfg.pid_limit)) <<< GAIN_FRAC_BITS;
    if (pid_raw > lim) begin
      pid = lim;
    end else if (pid_raw < -lim) begin
      pid = -lim;
    end else begin
      pid = pid_raw;
    end
    steer   = cfg.edge_sign ? -pid : pid;
    base_q  = ACC_W'(cfg.cruise_power) <<< GAIN_FRAC_BITS;
    left_q  = base_q + steer;
    right_q = base_q - steer;
    // round negative values with a fraction up, giving truncation toward zero
    left_int  = (left_q >>> GAIN_FRAC_BITS) +
                ACC_W'(left_q[ACC_W-1] && (left_q[GAIN_FRAC_BITS-1:0] != '0));
    right_int = (right_q >>> GAIN_FRAC_BITS) +
                ACC_W'(right_q[ACC_W-1] && (right_q[GAIN_FRAC_BITS-1:0] != '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && prod_valid) begin
      left_power  <= left_int[lfps_pkg::POWER_W-1:0];
      right_power <= right_int[lfps_pkg::POWER_W-1:0];
    end
  end

endmodule

// ===== dv/lfps_steering_checker.sv =====
// Checker for the line-follow PID steering block: mirrors the registers, predicts and compares.
`timescale 1ns / 1ps

module lfps_steering_checker #(
  parameter int SAMPLE_BITS    = 10,
  parameter int GAIN_FRAC_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [SAMPLE_BITS-1:0]              green_sample,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [lfps_pkg::POWER_W-1:0] left_power,
  input  logic signed [lfps_pkg::POWER_W-1:0] right_power,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [lfps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lfps_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                  mismatch_count,
  output int                                  pending_count,
  output int                                  checked_count
);

  typedef struct {
    logic signed [lfps_pkg::POWER_W-1:0] left;
    logic signed [lfps_pkg::POWER_W-1:0] right;
  } power_pair_t;

  lfps_pkg::cfg_t regs;
  longint         last_error;
  longint         error_pair_sum;
  power_pair_t    expected_powers [$];

  localparam longint ONE_Q = longint'(1) <<< GAIN_FRAC_BITS;

  // Advance the controller state by one sample and return the motor powers.
  function automatic power_pair_t steer_powers(input logic [SAMPLE_BITS-1:0] sample);
    longint      err;
    longint      delta;
    longint      sum_next;
    longint      pid;
    longint      lim;
    longint      steer;
    longint      base_q;
    longint      left_i;
    longint      right_i;
    power_pair_t p;
    err      = longint'(regs.target_level) - longint'(sample);
    delta    = err - last_error;
    sum_next = error_pair_sum + err + last_error;
    if (sum_next > 64'sd2147483647) sum_next = 64'sd2147483647;
    else if (sum_next < -64'sd2147483648) sum_next = -64'sd2147483648;
    error_pair_sum = sum_next;
    last_error     = err;
    pid = longint'(regs.kp_gain) * err + longint'(regs.ki_gain) * error_pair_sum
        + longint'(regs.kd_gain) * delta;
    lim = longint'(regs.pid_limit) * ONE_Q;
    if (pid > lim) pid = lim;
    else if (pid < -lim) pid = -lim;
    steer   = regs.edge_sign ? -pid : pid;
    base_q  = longint'(regs.cruise_power) * ONE_Q;
    left_i  = (base_q + steer) / ONE_Q;
    right_i = (base_q - steer) / ONE_Q;
    p.left  = left_i[lfps_pkg::POWER_W-1:0];
    p.right = right_i[lfps_pkg::POWER_W-1:0];
    return p;
  endfunction

  always @(posedge clk) begin
    power_pair_t want;
    if (rst) begin
      regs.target_level = lfps_pkg::RST_TARGET_LEVEL;
      regs.kp_gain      = lfps_pkg::RST_KP_GAIN;
      regs.ki_gain      = lfps_pkg::RST_KI_GAIN;
      regs.kd_gain      = lfps_pkg::RST_KD_GAIN;
      regs.pid_limit    = lfps_pkg::RST_PID_LIMIT;
      regs.cruise_power = lfps_pkg::RST_CRUISE_POWER;
      regs.edge_sign    = lfps_pkg::RST_EDGE_SIGN;
      last_error        = 0;
      error_pair_sum    = 0;
      expected_powers.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lfps_pkg::CFG_TARGET_LEVEL:
            regs.target_level = cfg_data[lfps_pkg::TARGET_W-1:0];
          lfps_pkg::CFG_KP_GAIN:      regs.kp_gain   = cfg_data[lfps_pkg::GAIN_W-1:0];
          lfps_pkg::CFG_KI_GAIN:      regs.ki_gain   = cfg_data[lfps_pkg::GAIN_W-1:0];
          lfps_pkg::CFG_KD_GAIN:      regs.kd_gain   = cfg_data[lfps_pkg::GAIN_W-1:0];
          lfps_pkg::CFG_PID_LIMIT:    regs.pid_limit = cfg_data[lfps_pkg::LIMIT_W-1:0];
          lfps_pkg::CFG_CRUISE_POWER:
            regs.cruise_power = cfg_data[lfps_pkg::BASE_W-1:0];
          lfps_pkg::CFG_EDGE_SIGN:    regs.edge_sign = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_powers.push_back(steer_powers(green_sample));
      if (out_valid && !out_stall) begin
        if (expected_powers.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result: left %0d right %0d with nothing outstanding",
                     left_power, right_power);
          mismatch_count++;
        end else begin
          want = expected_powers.pop_front();
          if (left_power !== want.left || right_power !== want.right) begin
            if (mismatch_count < 10)
              $display("mismatch on result %0d: left exp %0d got %0d, right exp %0d got %0d",
                       checked_count, want.left, left_power, want.right, right_power);
            mismatch_count++;
          end
          checked_count++;
        end
      end
    end
    pending_count = expected_powers.size();
  end

endmodule

// ===== dv/tb_line_follow_pid_steering_top.sv =====
// Testbench top for the line-follow PID steering block: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_line_follow_pid_steering_top;

  localparam int SAMPLE_BITS    = 10;
  localparam int GAIN_FRAC_BITS = 24;
  localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
  localparam int unsigned GAIN_MAX = (1 << lfps_pkg::GAIN_W) - 1;

  // Register index with no register behind it; writes to it must change nothing
  localparam logic [lfps_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  // Random segments
  localparam int SEGMENTS      = 8;
  localparam int SEGMENT_ITEMS = 215;

  // The slowest correct run is dominated by heavily idled segments;
  // the limit takes a wide margin over it.
  localparam int CYCLE_LIMIT = 200_000;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [SAMPLE_BITS-1:0]              green_sample = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [lfps_pkg::POWER_W-1:0] left_power;
  logic signed [lfps_pkg::POWER_W-1:0] right_power;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [lfps_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [lfps_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

  int mismatch_count;
  int pending_count;
  int checked_count;
  int cycle_count = 0;
  int sent_count  = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // Directed sample sequences
  int probes_reset [10] = '{85, 0, 1023, 84, 86, 341, 682, 1023, 0, 85};
  int probes_hi [8]     = '{0, 1023, 0, 1023, 512, 1023, 0, 1};
  int probes_lo [7]     = '{1023, 0, 1023, 1, 512, 0, 1023};

  // Settings currently loaded, kept so random samples can cluster around the setpoint
  lfps_pkg::cfg_t active_cfg;

  line_follow_pid_steering_top #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .green_sample (green_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .left_power   (left_power),
    .right_power  (right_power),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  lfps_steering_checker #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .green_sample   (green_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .left_power     (left_power),
    .right_power    (right_power),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver back-pressure: a fresh coin toss every cycle at the phase's stall rate
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Offer one sample and hold it until the block takes it. Valid stays high between
  // back-to-back transactions; it drops only when a gap is drawn.
  task automatic push_sample(input logic [SAMPLE_BITS-1:0] value);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_valid     <= 1'b1;
    green_sample <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // Stop sending and wait until every outstanding result has come back.
  // It waits on the clock before polling, so the checker has booked the last accepted sample.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // One register write; cfg_valid is left high so writes can go back to back.
  // Half the writes carry junk above the field to check that it is dropped.
  task automatic write_reg(input logic [lfps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] field, input int bits);
    logic [31:0] word;
    word = field;
    if ($urandom_range(0, 1) == 1) word = word | ($urandom << bits);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Load a full register set while the block is idle
  task automatic apply_settings(input lfps_pkg::cfg_t s, input bit poke_unmapped);
    drain_results();
    write_reg(lfps_pkg::CFG_TARGET_LEVEL, 32'(s.target_level), lfps_pkg::TARGET_W);
    write_reg(lfps_pkg::CFG_KP_GAIN,      32'(s.kp_gain),      lfps_pkg::GAIN_W);
    write_reg(lfps_pkg::CFG_KI_GAIN,      32'(s.ki_gain),      lfps_pkg::GAIN_W);
    write_reg(lfps_pkg::CFG_KD_GAIN,      32'(s.kd_gain),      lfps_pkg::GAIN_W);
    write_reg(lfps_pkg::CFG_PID_LIMIT,    32'(s.pid_limit),    lfps_pkg::LIMIT_W);
    write_reg(lfps_pkg::CFG_CRUISE_POWER, {24'd0, s.cruise_power}, lfps_pkg::BASE_W);
    write_reg(lfps_pkg::CFG_EDGE_SIGN,    32'(s.edge_sign),    1);
    if (poke_unmapped) write_reg(CFG_UNMAPPED, $urandom, 0);
    cfg_valid  <= 1'b0;
    active_cfg = s;
  endtask

  // Gains: zero and full scale now and then, otherwise spread over all magnitudes
  function automatic logic [lfps_pkg::GAIN_W-1:0] random_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return lfps_pkg::GAIN_W'(GAIN_MAX);
      default: return lfps_pkg::GAIN_W'($urandom_range(0, GAIN_MAX) >> $urandom_range(0, 25));
    endcase
  endfunction

  function automatic lfps_pkg::cfg_t random_settings();
    lfps_pkg::cfg_t s;
    int             base;
    s.target_level = lfps_pkg::TARGET_W'($urandom_range(0, SAMPLE_MAX));
    s.kp_gain      = random_gain();
    s.ki_gain      = random_gain();
    s.kd_gain      = random_gain();
    // Mostly in the documented range, sometimes the out-of-range codes up to 127 / -128
    if ($urandom_range(0, 7) == 0) s.pid_limit = lfps_pkg::LIMIT_W'($urandom_range(101, 127));
    else s.pid_limit = lfps_pkg::LIMIT_W'($urandom_range(0, 100));
    if ($urandom_range(0, 7) == 0) base = int'($urandom_range(0, 255)) - 128;
    else base = int'($urandom_range(0, 200)) - 100;
    s.cruise_power = base[lfps_pkg::BASE_W-1:0];
    s.edge_sign    = 1'($urandom_range(0, 1));
    return s;
  endfunction

  // Samples: rail values, anywhere, or close to the setpoint where the loop is unclamped
  function automatic logic [SAMPLE_BITS-1:0] random_sample();
    int v;
    case ($urandom_range(0, 7))
      0:       v = 0;
      1:       v = SAMPLE_MAX;
      2, 3:    v = int'($urandom_range(0, SAMPLE_MAX));
      default: v = int'(active_cfg.target_level) + int'($urandom_range(0, 80)) - 40;
    endcase
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return v[SAMPLE_BITS-1:0];
  endfunction

  initial begin
    lfps_pkg::cfg_t s;

    active_cfg.target_level = lfps_pkg::RST_TARGET_LEVEL;
    active_cfg.kp_gain      = lfps_pkg::RST_KP_GAIN;
    active_cfg.ki_gain      = lfps_pkg::RST_KI_GAIN;
    active_cfg.kd_gain      = lfps_pkg::RST_KD_GAIN;
    active_cfg.pid_limit    = lfps_pkg::RST_PID_LIMIT;
    active_cfg.cruise_power = lfps_pkg::RST_CRUISE_POWER;
    active_cfg.edge_sign    = lfps_pkg::RST_EDGE_SIGN;

    // Hold reset, then release it
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset defaults, full rate, rail samples and zero error
    foreach (probes_reset[i]) push_sample(SAMPLE_BITS'(probes_reset[i]));

    // Directed: every gain at full scale except ki, widest out-of-range clamp,
    // most negative base, edge flipped; also poke the unmapped index
    s.target_level = lfps_pkg::TARGET_W'(SAMPLE_MAX);
    s.kp_gain      = lfps_pkg::GAIN_W'(GAIN_MAX);
    s.ki_gain      = '0;
    s.kd_gain      = lfps_pkg::GAIN_W'(GAIN_MAX);
    s.pid_limit    = 7'd127;
    s.cruise_power = -8'sd128;
    s.edge_sign    = 1'b1;
    apply_settings(s, 1'b1);
    foreach (probes_hi[i]) push_sample(SAMPLE_BITS'(probes_hi[i]));

    // Directed: only the integral term, clamp at zero, most positive base
    s.target_level = '0;
    s.kp_gain      = '0;
    s.ki_gain      = lfps_pkg::GAIN_W'(GAIN_MAX);
    s.kd_gain      = '0;
    s.pid_limit    = '0;
    s.cruise_power = 8'sd127;
    s.edge_sign    = 1'b0;
    apply_settings(s, 1'b0);
    foreach (probes_lo[i]) push_sample(SAMPLE_BITS'(probes_lo[i]));

    // Random segments; idling cycles through none, sender, receiver, both
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      apply_settings(random_settings(), seg == 3);
      case (seg % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 88; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 88; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        // Mid-segment: let the pipeline empty completely before carrying on
        if (seg == 2 && n == SEGMENT_ITEMS / 2) drain_results();
        push_sample(random_sample());
      end
    end

    // Drain, then keep clocking so anything stray still shows up
    drain_results();
    repeat (16) @(posedge clk);

    $display("Sent %0d samples over %0d register sets, directed corners then random,",
             sent_count, SEGMENTS + 3);
    $display("with all four idling mixes; %0d results checked, %0d mismatches.",
             checked_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== line_follow_pid_steering_top.f =====
design/lfps_pkg.sv
design/lfps_error.sv
design/lfps_mult.sv
design/lfps_mix.sv
design/line_follow_pid_steering_top.sv
dv/lfps_steering_checker.sv
dv/tb_line_follow_pid_steering_top.sv
